>>> sv/assert_macros.svh
// Assertion macros for the top-level RTL file, which checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset
`define STDR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stdr assertion failed");

// Condition that must never be seen outside reset
`define STDR_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("stdr forbidden condition seen");

`endif

>>> sv/stdr_pkg.sv
// Types, constants and register codes of the step and turn dead-reckoning block
package stdr_pkg;

   // configuration register indexes
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 15;

   localparam logic [CsrIndexWidth-1:0] CSR_STEP_THRESHOLD = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_COUNT_MIN = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_THRESHOLD = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_COUNT_MIN = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_LENGTH_CM = 3'd4;

   // reset values of the registers
   localparam logic [14:0] STEP_THRESHOLD_RST = 15'd700;
   localparam logic [7:0]  STEP_COUNT_MIN_RST = 8'd1;
   localparam logic [14:0] TURN_THRESHOLD_RST = 15'd100;
   localparam logic [7:0]  TURN_COUNT_MIN_RST = 8'd90;
   localparam logic [9:0]  STEP_LENGTH_CM_RST = 10'd200;

   // input word kinds
   localparam logic CMD_ACCEL = 1'b0;
   localparam logic CMD_GYRO  = 1'b1;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [14:0] step_threshold;
      logic [7:0]  step_count_min;
      logic [14:0] turn_threshold;
      logic [7:0]  turn_count_min;
      logic [9:0]  step_length_cm;
   } cfg_type;

   // classified word handed from the front end to the back end
   typedef struct packed {
      logic        step;
      logic [15:0] yaw;
   } job_type;

   // queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> sv/stdr_ifs.sv
// Handshake channels of the step and turn dead-reckoning block
interface stdr_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface stdr_rsp_if;
   logic               valid;
   logic               ready;
   logic               step_detected;
   logic               waypoint_valid;
   logic signed [31:0] waypoint_x;
   logic signed [31:0] waypoint_y;
   logic [15:0]        waypoint_number;
   logic [1:0]         heading_quarters;

   modport source (output valid, output step_detected, output waypoint_valid,
                   output waypoint_x, output waypoint_y, output waypoint_number,
                   output heading_quarters, input ready);
   modport sink (input valid, input step_detected, input waypoint_valid,
                 input waypoint_x, input waypoint_y, input waypoint_number,
                 input heading_quarters, output ready);
endinterface

>>> sv/stdr_queue.sv
// Two-entry queue of classified words between the front and back ends
module stdr_queue
   import stdr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head_job,
   output qstat_type stat
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = entry_ff[rd_ptr_ff];
   assign stat.full  = count_ff[1];
   assign stat.empty = (count_ff == 2'd0);

endmodule

>>> sv/stdr_front.sv
// Front end: takes sensor words, runs the step and turn detectors
module stdr_front
   import stdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   stdr_req_if.sink   req_bus,
   input  qstat_type  qstat,
   output logic       push,
   output job_type    push_job
);

   logic [7:0]  high_cnt_ff, high_cnt_in;
   logic [7:0]  low_cnt_ff, low_cnt_in;
   logic        high_seen_ff, high_seen_in;
   logic        low_seen_ff, low_seen_in;
   logic [7:0]  pos_cnt_ff, pos_cnt_in;
   logic [7:0]  neg_cnt_ff, neg_cnt_in;
   logic [15:0] yaw_ff, yaw_in;

   logic signed [16:0] smp;
   logic signed [16:0] th_pos;
   logic signed [16:0] th_neg;
   logic               above;
   logic               below;
   logic               step;

   assign req_bus.ready = !qstat.full;
   assign push          = req_bus.valid && req_bus.ready;

   // threshold compare, shared by both sensors
   always_comb begin
      smp    = {req_bus.sample[15], req_bus.sample};
      th_pos = (req_bus.cmd == CMD_GYRO) ? $signed({2'b00, cfg.turn_threshold})
                                         : $signed({2'b00, cfg.step_threshold});
      th_neg = -th_pos;
      above  = smp > th_pos;
      below  = smp < th_neg;
   end

   // detector next state
   always_comb begin
      high_cnt_in  = high_cnt_ff;
      low_cnt_in   = low_cnt_ff;
      high_seen_in = high_seen_ff;
      low_seen_in  = low_seen_ff;
      pos_cnt_in   = pos_cnt_ff;
      neg_cnt_in   = neg_cnt_ff;
      yaw_in       = yaw_ff;
      step         = 1'b0;
      if (req_bus.cmd == CMD_ACCEL) begin
         if (above) begin
            low_cnt_in  = 8'd0;
            high_cnt_in = (high_cnt_ff == 8'hFF) ? high_cnt_ff : high_cnt_ff + 8'd1;
            if (high_cnt_in > cfg.step_count_min) begin
               high_seen_in = 1'b1;
            end
         end else if (below) begin
            high_cnt_in = 8'd0;
            low_cnt_in  = (low_cnt_ff == 8'hFF) ? low_cnt_ff : low_cnt_ff + 8'd1;
            if (low_cnt_in > cfg.step_count_min) begin
               low_seen_in = 1'b1;
            end
         end
         // both phases seen: a step, detector starts afresh
         if (high_seen_in && low_seen_in) begin
            step         = 1'b1;
            high_seen_in = 1'b0;
            low_seen_in  = 1'b0;
            high_cnt_in  = 8'd0;
            low_cnt_in   = 8'd0;
         end
      end else begin
         if (above) begin
            neg_cnt_in = 8'd0;
            pos_cnt_in = (pos_cnt_ff == 8'hFF) ? pos_cnt_ff : pos_cnt_ff + 8'd1;
            if (pos_cnt_in > cfg.turn_count_min) begin
               pos_cnt_in = 8'd0;
               yaw_in     = yaw_ff + 16'd1;
            end
         end else if (below) begin
            pos_cnt_in = 8'd0;
            neg_cnt_in = (neg_cnt_ff == 8'hFF) ? neg_cnt_ff : neg_cnt_ff + 8'd1;
            if (neg_cnt_in > cfg.turn_count_min) begin
               neg_cnt_in = 8'd0;
               yaw_in     = yaw_ff - 16'd1;
            end
         end
      end
   end

   assign push_job.step = step;
   assign push_job.yaw  = yaw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_cnt_ff  <= 8'd0;
         low_cnt_ff   <= 8'd0;
         high_seen_ff <= 1'b0;
         low_seen_ff  <= 1'b0;
         pos_cnt_ff   <= 8'd0;
         neg_cnt_ff   <= 8'd0;
         yaw_ff       <= 16'd0;
      end else if (push) begin
         high_cnt_ff  <= high_cnt_in;
         low_cnt_ff   <= low_cnt_in;
         high_seen_ff <= high_seen_in;
         low_seen_ff  <= low_seen_in;
         pos_cnt_ff   <= pos_cnt_in;
         neg_cnt_ff   <= neg_cnt_in;
         yaw_ff       <= yaw_in;
      end
   end

endmodule

>>> sv/stdr_back.sv
// Back end: leg tracking, waypoint arithmetic and result register
module stdr_back
   import stdr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  qstat_type qstat,
   input  job_type   head_job,
   output logic      pop,
   stdr_rsp_if.source rsp_bus
);

   // leg state
   logic [15:0] heading_ff, heading_in;
   logic [15:0] steps_ff, steps_in;
   logic [15:0] legs_ff, legs_in;
   logic signed [31:0] last_x_ff, last_x_in;
   logic signed [31:0] last_y_ff, last_y_in;

   // product stage
   logic        p_valid_ff;
   logic        p_step_ff, p_step_in;
   logic        p_wp_ff, p_wp_in;
   logic [1:0]  p_dir_ff, p_dir_in;
   logic [25:0] p_dist_ff, p_dist_in;
   logic [15:0] p_legs_ff;
   logic [1:0]  p_quarter_ff;

   // result register
   logic        o_valid_ff;
   logic        o_step_ff;
   logic        o_wp_ff;
   logic [15:0] o_legs_ff;
   logic [1:0]  o_quarter_ff;

   logic o_load;
   logic p_free;

   logic signed [31:0] base;
   logic signed [33:0] sum;
   logic signed [31:0] coord;

   // pipeline flow
   assign o_load = p_valid_ff && (!o_valid_ff || rsp_bus.ready);
   assign p_free = !p_valid_ff || o_load;
   assign pop    = !qstat.empty && p_free;

   // leg decision and distance product
   always_comb begin
      heading_in = heading_ff;
      steps_in   = steps_ff;
      legs_in    = legs_ff;
      p_step_in  = head_job.step;
      p_wp_in    = 1'b0;
      p_dir_in   = heading_ff[1:0];
      p_dist_in  = 26'(steps_ff) * 26'(cfg.step_length_cm);
      if (head_job.step) begin
         if (head_job.yaw == heading_ff) begin
            steps_in = (steps_ff == 16'hFFFF) ? steps_ff : steps_ff + 16'd1;
         end else begin
            p_wp_in    = 1'b1;
            legs_in    = (legs_ff == 16'hFFFF) ? legs_ff : legs_ff + 16'd1;
            heading_in = head_job.yaw;
            steps_in   = 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= 16'd0;
         steps_ff   <= 16'd0;
         legs_ff    <= 16'd0;
         p_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            heading_ff <= heading_in;
            steps_ff   <= steps_in;
            legs_ff    <= legs_in;
         end
         if (p_free) begin
            p_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_step_ff    <= p_step_in;
         p_wp_ff      <= p_wp_in;
         p_dir_ff     <= p_dir_in;
         p_dist_ff    <= p_dist_in;
         p_legs_ff    <= legs_in;
         p_quarter_ff <= head_job.yaw[1:0];
      end
   end

   // saturating move along the closed leg's heading: odd quarters on x
   always_comb begin
      base = p_dir_ff[0] ? last_x_ff : last_y_ff;
      if (p_dir_ff[1]) begin
         sum = {{2{base[31]}}, base} - $signed({8'd0, p_dist_ff});
      end else begin
         sum = {{2{base[31]}}, base} + $signed({8'd0, p_dist_ff});
      end
      if (sum[33:31] != 3'b000 && sum[33:31] != 3'b111) begin
         coord = sum[33] ? COORD_MIN : COORD_MAX;
      end else begin
         coord = sum[31:0];
      end
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      if (p_wp_ff) begin
         if (p_dir_ff[0]) begin
            last_x_in = coord;
         end else begin
            last_y_in = coord;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         last_x_ff  <= 32'sd0;
         last_y_ff  <= 32'sd0;
      end else begin
         if (o_load) begin
            o_valid_ff <= 1'b1;
            last_x_ff  <= last_x_in;
            last_y_ff  <= last_y_in;
         end else if (rsp_bus.ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_step_ff    <= p_step_ff;
         o_wp_ff      <= p_wp_ff;
         o_legs_ff    <= p_legs_ff;
         o_quarter_ff <= p_quarter_ff;
      end
   end

   // result word; coordinates come straight from the last waypoint
   assign rsp_bus.valid            = o_valid_ff;
   assign rsp_bus.step_detected    = o_step_ff;
   assign rsp_bus.waypoint_valid   = o_wp_ff;
   assign rsp_bus.waypoint_x       = last_x_ff;
   assign rsp_bus.waypoint_y       = last_y_ff;
   assign rsp_bus.waypoint_number  = o_legs_ff;
   assign rsp_bus.heading_quarters = o_quarter_ff;

endmodule

>>> sv/step_turn_dead_reckoning.sv
// Top level of the step and turn dead-reckoning block
//
// Sensor words enter on req_bus: cmd selects an accelerometer sample (mg) or
// a gyro yaw-rate sample (dps), each a signed 16-bit reading. Every accepted
// word yields exactly one result word on rsp_bus, in order: step flag,
// waypoint flag, the last waypoint in cm, the waypoint count and the heading
// in quarter turns.
// One word per cycle is sustained while rsp_bus.ready stays high; the front
// end updates the detectors in the cycle a word is taken, the back end
// makes the leg decision and the steps-times-length product in the product
// stage and the saturating coordinate add into the result register.
// A two-entry queue sits between front and back, so a stalled receiver
// first fills the result register, then the product stage, then the queue;
// only then does req_bus.ready fall.
// Registers are written through csr_we/csr_index/csr_wdata, by the user
// only while idle, unenforced by the block; unknown indexes are ignored.
// Synchronous reset clears all detectors, the leg state and the pipeline
// and loads the register defaults; no clearing pass follows.
`include "assert_macros.svh"

module step_turn_dead_reckoning
   import stdr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   stdr_req_if.sink                 req_bus,
   stdr_rsp_if.source               rsp_bus,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   qstat_type qstat;
   job_type   push_job;
   job_type   head_job;
   logic      push;
   logic      pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP_THRESHOLD: cfg_in.step_threshold = csr_wdata;
            CSR_STEP_COUNT_MIN: cfg_in.step_count_min = csr_wdata[7:0];
            CSR_TURN_THRESHOLD: cfg_in.turn_threshold = csr_wdata;
            CSR_TURN_COUNT_MIN: cfg_in.turn_count_min = csr_wdata[7:0];
            CSR_STEP_LENGTH_CM: cfg_in.step_length_cm = csr_wdata[9:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_threshold <= STEP_THRESHOLD_RST;
         cfg_ff.step_count_min <= STEP_COUNT_MIN_RST;
         cfg_ff.turn_threshold <= TURN_THRESHOLD_RST;
         cfg_ff.turn_count_min <= TURN_COUNT_MIN_RST;
         cfg_ff.step_length_cm <= STEP_LENGTH_CM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stdr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_bus  (req_bus),
      .qstat    (qstat),
      .push     (push),
      .push_job (push_job)
   );

   stdr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (qstat)
   );

   stdr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .qstat    (qstat),
      .head_job (head_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

   // checks
   `STDR_ASSERT(a_wp_needs_step, clock, reset, rsp_bus.valid && rsp_bus.waypoint_valid |-> rsp_bus.step_detected)
   `STDR_NEVER(a_no_push_full, clock, reset, push && qstat.full)
   `STDR_NEVER(a_no_pop_empty, clock, reset, pop && qstat.empty)
   `STDR_ASSERT(a_idle_after_reset, clock, 1'b0, $past(reset) |-> !rsp_bus.valid)

endmodule

>>> tb/sv/step_turn_dead_reckoning_tb.sv
// Self-checking bench for the step and turn dead-reckoning block
module step_turn_dead_reckoning_tb;
   import stdr_pkg::*;

   localparam int STALL_LIMIT = 3000;   // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 8;     // margin after the drain before the final check
   localparam int PHASES = 8;

   // indexes the block does not decode
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_HI = 3'd7;

   // heading of a leg, quarter turns modulo four
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;

   typedef struct packed {
      logic               step_detected;
      logic               waypoint_valid;
      logic signed [31:0] waypoint_x;
      logic signed [31:0] waypoint_y;
      logic [15:0]        waypoint_number;
      logic [1:0]         heading_quarters;
   } track_report_type;

   localparam track_report_type AT_REST_REPORT = '0;
   localparam track_report_type FIRST_STEP_REPORT = '{1'b1, 1'b0, 32'sd0, 32'sd0, 16'd0, 2'd0};

   typedef enum logic [1:0] {PLAN_WRITE, PLAN_CHECKED, PLAN_AT_REST, PLAN_FIRST_STEP}
      plan_kind_type;

   typedef struct packed {
      plan_kind_type            kind;
      logic [CsrIndexWidth-1:0] reg_idx;
      logic [CsrDataWidth-1:0]  wdata;
      logic                     cmd;
      logic [15:0]              smp;
   } plan_row_type;

   localparam int PLAN_ROWS = 36;

   // directed opening: reset settings, then zero thresholds, then the extremes
   plan_row_type plan_table [PLAN_ROWS] = '{
      '{PLAN_AT_REST,    '0, '0, CMD_GYRO,  16'd0},
      '{PLAN_AT_REST,    '0, '0, CMD_ACCEL, 16'h7FFF},
      '{PLAN_AT_REST,    '0, '0, CMD_ACCEL, 16'h7FFF},   // high phase seen
      '{PLAN_AT_REST,    '0, '0, CMD_ACCEL, 16'h8000},
      '{PLAN_FIRST_STEP, '0, '0, CMD_ACCEL, 16'h8000},   // low phase completes the step
      '{PLAN_AT_REST,    '0, '0, CMD_ACCEL, 16'sd700},   // on the threshold: inside
      '{PLAN_AT_REST,    '0, '0, CMD_ACCEL, -16'sd700},
      '{PLAN_AT_REST,    '0, '0, CMD_GYRO,  16'h7FFF},
      '{PLAN_AT_REST,    '0, '0, CMD_GYRO,  16'h8000},
      '{PLAN_AT_REST,    '0, '0, CMD_GYRO,  16'sd100},
      '{PLAN_AT_REST,    '0, '0, CMD_GYRO,  -16'sd100},
      '{PLAN_WRITE, CSR_TURN_COUNT_MIN, 15'd0,    CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_STEP_COUNT_MIN, 15'd0,    CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_STEP_THRESHOLD, 15'd0,    CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_TURN_THRESHOLD, 15'd0,    CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_STEP_LENGTH_CM, 15'd1023, CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_SPARE_LO,       15'h7FFF, CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_SPARE_HI,       15'h7FFF, CMD_ACCEL, 16'd0},
      '{PLAN_CHECKED,    '0, '0, CMD_GYRO,  16'd1},      // quarter turn east
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'd1},
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'hFFFF},   // step on a new heading: waypoint
      '{PLAN_CHECKED,    '0, '0, CMD_GYRO,  16'hFFFF},
      '{PLAN_CHECKED,    '0, '0, CMD_GYRO,  16'hFFFF},   // yaw wraps below zero
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'd0},
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'hFFFB},   // low phase first this time
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'd5},
      '{PLAN_WRITE, CSR_STEP_THRESHOLD, 15'h7FFF, CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_TURN_THRESHOLD, 15'h7FFF, CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_STEP_COUNT_MIN, 15'h7FFE, CMD_ACCEL, 16'd0},   // upper bits dropped
      '{PLAN_WRITE, CSR_TURN_COUNT_MIN, 15'h7FFE, CMD_ACCEL, 16'd0},
      '{PLAN_WRITE, CSR_STEP_LENGTH_CM, 15'h7C00, CMD_ACCEL, 16'd0},
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'h7FFF},
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'h8000},
      '{PLAN_CHECKED,    '0, '0, CMD_GYRO,  16'h7FFF},
      '{PLAN_CHECKED,    '0, '0, CMD_GYRO,  16'h8000},
      '{PLAN_CHECKED,    '0, '0, CMD_ACCEL, 16'h8001}
   };

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   stdr_req_if req_bus ();
   stdr_rsp_if rsp_bus ();

   step_turn_dead_reckoning i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // tracker state mirrored from the block
   cfg_type            trk_cfg;
   logic [7:0]         rise_run, fall_run, cw_run, ccw_run;
   logic               rise_seen, fall_seen;
   logic [15:0]        yaw_q, leg_dir, leg_len, legs_done;
   logic signed [31:0] pos_x, pos_y;

   track_report_type report_q [$];
   int  fail_count = 0;
   int  words_sent = 0;
   int  settings_count = 0;
   int  step_total = 0;
   int  waypoint_total = 0;
   int  turn_total = 0;
   int  stall_cycles = 0;
   bit  quiet = 1'b0;

   function automatic void reset_tracker();
      trk_cfg.step_threshold = STEP_THRESHOLD_RST;
      trk_cfg.step_count_min = STEP_COUNT_MIN_RST;
      trk_cfg.turn_threshold = TURN_THRESHOLD_RST;
      trk_cfg.turn_count_min = TURN_COUNT_MIN_RST;
      trk_cfg.step_length_cm = STEP_LENGTH_CM_RST;
      rise_run = '0; fall_run = '0; cw_run = '0; ccw_run = '0;
      rise_seen = 1'b0; fall_seen = 1'b0;
      yaw_q = '0; leg_dir = '0; leg_len = '0; legs_done = '0;
      pos_x = '0; pos_y = '0;
   endfunction

   // register write as the block decodes it; unknown indexes fall through
   function automatic void store_reg(logic [CsrIndexWidth-1:0] idx,
                                     logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_STEP_THRESHOLD: trk_cfg.step_threshold = data[14:0];
         CSR_STEP_COUNT_MIN: trk_cfg.step_count_min = data[7:0];
         CSR_TURN_THRESHOLD: trk_cfg.turn_threshold = data[14:0];
         CSR_TURN_COUNT_MIN: trk_cfg.turn_count_min = data[7:0];
         CSR_STEP_LENGTH_CM: trk_cfg.step_length_cm = data[9:0];
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] run_inc(logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic signed [31:0] coord_add(logic signed [31:0] base, longint delta);
      longint s;
      s = longint'(base) + delta;
      if (s > longint'(COORD_MAX)) return COORD_MAX;
      if (s < longint'(COORD_MIN)) return COORD_MIN;
      return 32'(s);
   endfunction

   // one sensor word through the tracker; returns the result word it causes
   function automatic track_report_type track_word(logic cmd, logic signed [15:0] smp);
      track_report_type rep;
      int     v, th;
      longint leg_span;
      logic   stepped;
      v = int'(smp);
      stepped = 1'b0;
      rep = '0;
      if (cmd == CMD_ACCEL) begin
         th = int'(trk_cfg.step_threshold);
         if (v > th) begin
            fall_run = '0;
            rise_run = run_inc(rise_run);
            if (rise_run > trk_cfg.step_count_min) rise_seen = 1'b1;
         end else if (v < -th) begin
            rise_run = '0;
            fall_run = run_inc(fall_run);
            if (fall_run > trk_cfg.step_count_min) fall_seen = 1'b1;
         end
         if (rise_seen && fall_seen) begin
            stepped = 1'b1;
            rise_seen = 1'b0; fall_seen = 1'b0;
            rise_run = '0; fall_run = '0;
            step_total++;
         end
         if (stepped) begin
            if (yaw_q == leg_dir) begin
               if (leg_len != 16'hFFFF) leg_len++;
            end else begin
               // close the leg along its old heading
               leg_span = longint'(leg_len) * longint'(trk_cfg.step_length_cm);
               case (leg_dir[1:0])
                  DIR_NORTH: pos_y = coord_add(pos_y, leg_span);
                  DIR_EAST:  pos_x = coord_add(pos_x, leg_span);
                  DIR_SOUTH: pos_y = coord_add(pos_y, -leg_span);
                  default:   pos_x = coord_add(pos_x, -leg_span);
               endcase
               if (legs_done != 16'hFFFF) legs_done++;
               leg_dir = yaw_q;
               leg_len = 16'd1;
               rep.waypoint_valid = 1'b1;
               waypoint_total++;
            end
         end
      end else begin
         th = int'(trk_cfg.turn_threshold);
         if (v > th) begin
            ccw_run = '0;
            cw_run = run_inc(cw_run);
            if (cw_run > trk_cfg.turn_count_min) begin
               cw_run = '0;
               yaw_q++;
               turn_total++;
            end
         end else if (v < -th) begin
            cw_run = '0;
            ccw_run = run_inc(ccw_run);
            if (ccw_run > trk_cfg.turn_count_min) begin
               ccw_run = '0;
               yaw_q--;
               turn_total++;
            end
         end
      end
      rep.step_detected = stepped;
      rep.waypoint_x = pos_x;
      rep.waypoint_y = pos_y;
      rep.waypoint_number = legs_done;
      rep.heading_quarters = yaw_q[1:0];
      return rep;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // reading beyond +/-th, clipped to the 16-bit range; at th = 32767 the positive one equals th
   function automatic logic signed [15:0] beyond(logic [14:0] th, bit neg);
      int v;
      if (neg) v = -int'($urandom_range(32768, 32'(th) + 1));
      else if (th == 15'h7FFF) v = 32767;
      else v = int'($urandom_range(32767, 32'(th) + 1));
      return 16'(v);
   endfunction

   task automatic send_word(logic cmd, logic signed [15:0] smp, plan_kind_type kind);
      int gap;
      track_report_type rep;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.sample <= smp;
      do @(posedge clock); while (!req_bus.ready);
      rep = track_word(cmd, smp);
      case (kind)
         PLAN_AT_REST:    report_q.push_back(AT_REST_REPORT);
         PLAN_FIRST_STEP: report_q.push_back(FIRST_STEP_REPORT);
         default:         report_q.push_back(rep);
      endcase
      words_sent++;
   endtask

   // stop sending and wait for every outstanding result word
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (report_q.size() != 0);
   endtask

   // csr_we stays high across back-to-back writes; the caller lowers it
   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_reg(idx, data);
   endtask

   function automatic logic [14:0] pick_threshold();
      int r;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 22) return 15'h7FFF;
      if (r < 75) return 15'($urandom_range(2000, 1));
      return 15'($urandom_range(32767));
   endfunction

   function automatic logic [7:0] pick_count(bit extreme);
      if (extreme) return 8'd254;
      if ($urandom_range(99) < 75) return 8'($urandom_range(3));
      return 8'($urandom_range(12, 4));
   endfunction

   function automatic logic [9:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 20) return '0;
      if (r < 40) return 10'd1023;
      return 10'($urandom_range(1023));
   endfunction

   // new settings for a random phase, with junk in the unused upper bits
   task automatic apply_settings(bit extreme);
      cfg_type c;
      c.step_threshold = pick_threshold();
      c.step_count_min = pick_count(extreme);
      c.turn_threshold = pick_threshold();
      c.turn_count_min = pick_count(extreme);
      c.step_length_cm = pick_length();
      drain();
      write_reg(CSR_STEP_THRESHOLD, c.step_threshold);
      write_reg(CSR_STEP_COUNT_MIN, {7'($urandom), c.step_count_min});
      write_reg(CSR_TURN_THRESHOLD, c.turn_threshold);
      write_reg(CSR_TURN_COUNT_MIN, {7'($urandom), c.turn_count_min});
      write_reg(CSR_STEP_LENGTH_CM, {5'($urandom), c.step_length_cm});
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // one stretch of stimulus: a full step, a full turn, a broken run or noise
   task automatic send_burst();
      int   pick, n, extra;
      bit   lows_first, neg;
      logic cmd;
      pick = $urandom_range(99);
      if (pick < 45) begin
         lows_first = 1'($urandom_range(1));
         for (int half = 0; half < 2; half++) begin
            extra = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
            n = int'(trk_cfg.step_count_min) + 1 + extra;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(9) == 0)
                  send_word(CMD_GYRO, 16'($urandom), PLAN_CHECKED);
               send_word(CMD_ACCEL, beyond(trk_cfg.step_threshold, (half == 1) ^ lows_first),
                         PLAN_CHECKED);
            end
         end
      end else if (pick < 75) begin
         neg = 1'($urandom_range(1));
         n = int'(trk_cfg.turn_count_min) + 1 + $urandom_range(1);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
               send_word(CMD_ACCEL, 16'($urandom), PLAN_CHECKED);
            send_word(CMD_GYRO, beyond(trk_cfg.turn_threshold, neg), PLAN_CHECKED);
         end
      end else if (pick < 90) begin
         // run cut short, usually before it counts
         cmd = 1'($urandom_range(1));
         neg = 1'($urandom_range(1));
         n = (cmd == CMD_ACCEL) ? int'(trk_cfg.step_count_min) : int'(trk_cfg.turn_count_min);
         n = $urandom_range(n + 1, 1);
         for (int i = 0; i < n; i++)
            send_word(cmd, beyond((cmd == CMD_ACCEL) ? trk_cfg.step_threshold
                                                     : trk_cfg.turn_threshold, neg),
                      PLAN_CHECKED);
      end else begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++)
            send_word(1'($urandom), 16'($urandom), PLAN_CHECKED);
      end
   endtask

   // result side: random stalls, with quiet stretches now and then
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(299) == 0) quiet = !quiet;
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(3) == 0) hold = idle_gap();
         end
      end
   end

   function automatic void check_field(string name, logic signed [32:0] want,
                                       logic signed [32:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // sampled at the falling edge ahead of the rising edge that completes the handshake
   always @(negedge clock) begin
      track_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (report_q.size() == 0) begin
            $error("result word arrived with nothing expected");
            fail_count++;
         end else begin
            want = report_q.pop_front();
            check_field("step_detected", want.step_detected, rsp_bus.step_detected);
            check_field("waypoint_valid", want.waypoint_valid, rsp_bus.waypoint_valid);
            check_field("waypoint_x", want.waypoint_x, rsp_bus.waypoint_x);
            check_field("waypoint_y", want.waypoint_y, rsp_bus.waypoint_y);
            check_field("waypoint_number", want.waypoint_number, rsp_bus.waypoint_number);
            check_field("heading_quarters", want.heading_quarters, rsp_bus.heading_quarters);
         end
      end
   end

   // watchdog on handshakes of either channel
   always @(negedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      bit csr_open;
      int phase_start;
      csr_open = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_ACCEL;
      req_bus.sample = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_tracker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan_table[r]) begin
         if (plan_table[r].kind == PLAN_WRITE) begin
            if (!csr_open) begin
               drain();
               csr_open = 1'b1;
            end
            write_reg(plan_table[r].reg_idx, plan_table[r].wdata);
         end else begin
            if (csr_open) begin
               csr_we <= 1'b0;
               csr_open = 1'b0;
               settings_count++;
            end
            send_word(plan_table[r].cmd, plan_table[r].smp, plan_table[r].kind);
         end
      end

      // random phases; one with the longest phase and turn runs
      for (int p = 0; p < PHASES; p++) begin
         apply_settings(p == 3);
         phase_start = words_sent;
         while (words_sent - phase_start < ((p == 3) ? 620 : 170)) send_burst();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (report_q.size() != 0) begin
         $error("%0d result words never arrived", report_q.size());
         fail_count++;
      end
      $display("%0d sensor words over %0d register settings: %0d steps, %0d waypoints, %0d turns",
               words_sent, settings_count, step_total, waypoint_total, turn_total);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
